### rtl/core/a5cw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a5cw_pkg: shared types and functions of the A5/1 chain walker
// Queue entry layout, register reset value and one majority clocking.
// ----------------------------------------------------------------------------
package a5cw_pkg;

	localparam int unsigned STATE_W = 64;
	localparam int unsigned LINKS_W = 16;
	localparam logic [LINKS_W-1:0] MAX_LINKS_RESET = 16'd5000;
	localparam int unsigned DP_SHIFT = 52;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [STATE_W-1:0] start_state;
		logic [STATE_W-1:0] reduction_value;
		logic [STATE_W-1:0] challenge;
		logic               trivial;
	} entry_t;

	function automatic logic [STATE_W-1:0] clock_once(input logic [STATE_W-1:0] r);
		logic a;
		logic b;
		logic c;
		logic maj;
		logic [STATE_W-1:0] nr;
		a   = r[8];
		b   = r[29];
		c   = r[51];
		maj = (a & b) | (a & c) | (b & c);
		nr  = r;
		if (a == maj) begin
			nr[18:0] = {r[17:0], r[18] ^ r[17] ^ r[16] ^ r[13]};
		end
		if (b == maj) begin
			nr[40:19] = {r[39:19], r[40] ^ r[39]};
		end
		if (c == maj) begin
			nr[63:41] = {r[62:41], r[63] ^ r[62] ^ r[61] ^ r[48]};
		end
		return nr;
	endfunction

	function automatic logic out_bit(input logic [STATE_W-1:0] r);
		return r[18] ^ r[40] ^ r[63];
	endfunction

endpackage

### rtl/core/a5_1_chain_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a5_1_chain_walker: A5/1 rainbow chain walk with distinguished points
// Front queue feeds a one-clocking-per-cycle chain engine.
// ----------------------------------------------------------------------------
// channel   direction  beat contents
// s_*       in         tdata: start_state, reduction_value, challenge
// m_*       out        tdata: end_state; tuser: reached_end, challenge_found
// cfg_*     in         max_links, written when cfg_we is high
//
// Each link runs a reduction XOR state, then one A5/1 clocking per cycle in
// the engine, then the challenge compare.
// Reset clears the queue and the engine and sets max_links to 5000.
// Two beats may wait in the queue while the engine or the output stalls.
// ----------------------------------------------------------------------------
module a5_1_chain_walker #(
	parameter int unsigned DUMMY_OUTPUTS = 99
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// start_state, reduction_value, challenge
	input  logic [3*a5cw_pkg::STATE_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// end_state
	output logic [a5cw_pkg::STATE_W-1:0]       m_tdata,
	// reached_end, challenge_found
	output logic [1:0]                         m_tuser,
	input  logic                               cfg_we,
	input  logic [a5cw_pkg::LINKS_W-1:0]       cfg_wdata
);

	logic [a5cw_pkg::LINKS_W-1:0] max_links_q;
	logic                         q_valid;
	logic                         q_pop;
	a5cw_pkg::entry_t             q_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_links_q <= a5cw_pkg::MAX_LINKS_RESET;
		end else if (cfg_we) begin
			max_links_q <= cfg_wdata;
		end
	end

	a5cw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.max_links (max_links_q),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop)
	);

	a5cw_back #(
		.DUMMY_OUTPUTS (DUMMY_OUTPUTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.max_links (max_links_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

### rtl/core/a5cw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a5cw_front: input side of the chain walker
// Accepts beats, marks walks that finish without a link and queues them.
// ----------------------------------------------------------------------------
module a5cw_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [3*a5cw_pkg::STATE_W-1:0]        s_tdata,
	input  logic [a5cw_pkg::LINKS_W-1:0]          max_links,
	output logic                                  q_valid,
	output a5cw_pkg::entry_t                      q_entry,
	input  logic                                  q_pop
);

	a5cw_pkg::entry_t                    mem_q [a5cw_pkg::QUEUE_DEPTH];
	logic [a5cw_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [a5cw_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [a5cw_pkg::QCNT_W-1:0]         cnt_q;
	a5cw_pkg::entry_t                    new_entry;
	logic                                push;
	logic                                pop;

	assign s_tready = (cnt_q != a5cw_pkg::QCNT_W'(a5cw_pkg::QUEUE_DEPTH));
	assign push     = s_tvalid & s_tready;
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_pop & q_valid;
	assign q_entry  = mem_q[rd_ptr_q];

	always_comb begin
		new_entry.start_state     = s_tdata[63:0];
		new_entry.reduction_value = s_tdata[127:64];
		new_entry.challenge       = s_tdata[191:128];
		new_entry.trivial         = (s_tdata[63:0] == '0) || (max_links == '0);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == a5cw_pkg::QPTR_W'(a5cw_pkg::QUEUE_DEPTH - 1)) ?
				            '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == a5cw_pkg::QPTR_W'(a5cw_pkg::QUEUE_DEPTH - 1)) ?
				            '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/a5cw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a5cw_back: chain engine of the chain walker
// Walks links with one A5/1 clocking per cycle and registers the result.
// ----------------------------------------------------------------------------
module a5cw_back #(
	parameter int unsigned DUMMY_OUTPUTS = 99
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_valid,
	input  a5cw_pkg::entry_t                   q_entry,
	output logic                               q_pop,
	input  logic [a5cw_pkg::LINKS_W-1:0]       max_links,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [a5cw_pkg::STATE_W-1:0]       m_tdata,
	output logic [1:0]                         m_tuser
);

	localparam int unsigned STEPS  = DUMMY_OUTPUTS + 64;
	localparam int unsigned STEP_W = $clog2(STEPS);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_XOR  = 5'b00010,
		S_CLK  = 5'b00100,
		S_CHK  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t                          state_q;
	logic [a5cw_pkg::STATE_W-1:0]    st_q;
	logic [a5cw_pkg::STATE_W-1:0]    rv_q;
	logic [a5cw_pkg::STATE_W-1:0]    ch_q;
	logic [a5cw_pkg::STATE_W-1:0]    r_q;
	logic [a5cw_pkg::STATE_W-1:0]    ks_q;
	logic [a5cw_pkg::LINKS_W-1:0]    z_q;
	logic [STEP_W-1:0]               step_q;
	logic                            reached_q;
	logic                            found_q;
	logic                            m_tvalid_q;
	logic [a5cw_pkg::STATE_W-1:0]    m_tdata_q;
	logic [1:0]                      m_tuser_q;
	logic [a5cw_pkg::STATE_W-1:0]    st_x;
	logic [a5cw_pkg::STATE_W-1:0]    r_next;
	logic [a5cw_pkg::LINKS_W-1:0]    z_next;
	logic                            out_free;

	assign st_x     = st_q ^ rv_q;
	assign r_next   = a5cw_pkg::clock_once(r_q);
	assign z_next   = z_q + 1'b1;
	assign out_free = !m_tvalid_q || m_tready;
	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					st_q      <= q_entry.start_state;
					rv_q      <= q_entry.reduction_value;
					ch_q      <= q_entry.challenge;
					z_q       <= '0;
					reached_q <= (q_entry.start_state == '0);
					found_q   <= 1'b0;
				end
			end
			S_XOR: begin
				st_q      <= st_x;
				r_q       <= st_x;
				step_q    <= '0;
				reached_q <= (z_q != '0) && (st_x[63:a5cw_pkg::DP_SHIFT] == '0);
			end
			S_CLK: begin
				r_q    <= r_next;
				step_q <= step_q + 1'b1;
				if (step_q >= STEP_W'(DUMMY_OUTPUTS)) begin
					ks_q <= {ks_q[62:0], a5cw_pkg::out_bit(r_next)};
				end
			end
			S_CHK: begin
				if (ks_q == ch_q) begin
					found_q <= 1'b1;
				end else begin
					st_q <= ks_q;
					z_q  <= z_next;
				end
			end
			default: begin
			end
		endcase
		if (state_q == S_OUT && out_free) begin
			m_tdata_q <= st_q;
			m_tuser_q <= {found_q, reached_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						state_q <= q_entry.trivial ? S_OUT : S_XOR;
					end
				end
				S_XOR: begin
					if ((z_q != '0) && (st_x[63:a5cw_pkg::DP_SHIFT] == '0)) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_CLK;
					end
				end
				S_CLK: begin
					if (step_q == STEP_W'(STEPS - 1)) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if ((ks_q == ch_q) || (z_next == max_links)) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_XOR;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
